### rtl/voas_pkg.sv
// Shared types and constants for the voice allocator with oldest-note stealing.
// Used by voas_cell and voice_allocator_oldest_steal_unit; depends on nothing.
`default_nettype none

package voas_pkg;

   localparam int TIME_W           = 32;
   localparam int HANDLE_W         = 32;
   localparam int SLOT_W           = 4;
   localparam int COUNT_W          = 5;
   localparam int CFG_W            = 5;
   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int MAX_VOICES_RESET = 4;

   // Search token handed from cell to cell; best index and count travel beside it.
   typedef struct packed {
      logic                valid;
      logic                found;
      logic [TIME_W-1:0]   best_start;
      logic [HANDLE_W-1:0] best_handle;
   } token_type;

   // Update of the chosen slot.
   typedef struct packed {
      logic                en;
      logic [TIME_W-1:0]   start;
      logic [HANDLE_W-1:0] handle;
   } write_type;

endpackage

`default_nettype wire

### rtl/voice_allocator_oldest_steal_unit.sv
// Top level of the voice allocator with oldest-note stealing: control, handle
// counter, result register and the chain of voas_cell slots. Depends on voas_pkg.
//
// Usage:
//   req channel carries one note trigger (req_start_time); a transfer happens
//   when req_valid is high and req_stall is low. rsp channel returns one result
//   per trigger: slot, note handle, stolen flag and active slot count.
//   csr_wr_en writes csr_wr_data into max_voices, clamped to 1..NUM_SLOTS;
//   write only while the block is idle.
// Sequence:
//   A search token walks the slot chain one cell per cycle; the unit captures
//   it after the last cell, loads the result register and raises rsp_valid,
//   and takes the next trigger only once the previous one has been loaded.
//   The length of the slot chain sets how long the walk lasts.
// Reset:
//   Synchronous, active high. All slots become free, the handle counter goes
//   to one and max_voices to four (clamped to NUM_SLOTS).
// Stall:
//   While rsp_stall holds a result, the next trigger is still taken and
//   searched; its slot update and result wait until the output register frees.
`default_nettype none

module voice_allocator_oldest_steal_unit #(
   parameter int NUM_SLOTS = voas_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [voas_pkg::TIME_W-1:0]       req_start_time,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [voas_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [voas_pkg::HANDLE_W-1:0]    rsp_note_handle,
   output logic                             rsp_stolen,
   output logic [voas_pkg::COUNT_W-1:0]     rsp_active_count,
   input  wire                              csr_wr_en,
   input  wire [voas_pkg::CFG_W-1:0]        csr_wr_data
);

   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
   localparam int LIM_RESET = (voas_pkg::MAX_VOICES_RESET > NUM_SLOTS) ?
                              NUM_SLOTS : voas_pkg::MAX_VOICES_RESET;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CNT_W-1:0]              lim_ff, lim_in;
   logic [voas_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic [voas_pkg::TIME_W-1:0]   start_ff;
   logic [IDX_W-1:0]              best_ff;
   logic                          found_ff;
   logic [CNT_W-1:0]              cnt_ff;

   logic                          rsp_valid_ff;
   logic [voas_pkg::SLOT_W-1:0]   rsp_slot_ff;
   logic [voas_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic                          rsp_stolen_ff;
   logic [voas_pkg::COUNT_W-1:0]  rsp_count_ff;

   logic                          launch;
   logic                          capture;
   logic                          load;
   voas_pkg::write_type           wr;

   voas_pkg::token_type           tok [NUM_SLOTS+1];
   logic [IDX_W-1:0]              idx [NUM_SLOTS+1];
   logic [CNT_W-1:0]              cnt [NUM_SLOTS+1];

   assign req_stall = (state_ff != ST_IDLE);
   assign launch    = req_valid && !req_stall;
   assign capture   = (state_ff == ST_SCAN) && tok[NUM_SLOTS].valid;
   assign load      = (state_ff == ST_WRITE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      tok[0].valid       = launch;
      tok[0].found       = 1'b0;
      tok[0].best_start  = '0;
      tok[0].best_handle = '0;
      idx[0]             = '0;
      cnt[0]             = '0;
   end

   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      voas_cell #(
         .NUM_SLOTS (NUM_SLOTS),
         .IDX       (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .lim     (lim_ff),
         .tok_in  (tok[g]),
         .idx_in  (idx[g]),
         .cnt_in  (cnt[g]),
         .tok_out (tok[g+1]),
         .idx_out (idx[g+1]),
         .cnt_out (cnt[g+1]),
         .wr      (wr),
         .wr_idx  (best_ff)
      );
   end

   always_comb begin
      wr.en     = load;
      wr.start  = start_ff;
      wr.handle = handle_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (launch) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (capture) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      lim_in = lim_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            lim_in = CNT_W'(1);
         end else if (int'(csr_wr_data) > NUM_SLOTS) begin
            lim_in = CNT_W'(NUM_SLOTS);
         end else begin
            lim_in = CNT_W'(csr_wr_data);
         end
      end
   end

   always_comb begin
      handle_in = handle_ff;
      if (load) begin
         handle_in = handle_ff + 1'b1;
         if (handle_in == '0) begin
            handle_in = voas_pkg::HANDLE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lim_ff       <= CNT_W'(LIM_RESET);
         handle_ff    <= voas_pkg::HANDLE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         lim_ff    <= lim_in;
         handle_ff <= handle_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (launch) begin
         start_ff <= req_start_time;
      end
      if (capture) begin
         best_ff  <= idx[NUM_SLOTS];
         found_ff <= tok[NUM_SLOTS].found;
         cnt_ff   <= CNT_W'(cnt[NUM_SLOTS] + CNT_W'(tok[NUM_SLOTS].found));
      end
      if (load) begin
         rsp_slot_ff   <= voas_pkg::SLOT_W'(best_ff);
         rsp_handle_ff <= handle_ff;
         rsp_stolen_ff <= !found_ff;
         rsp_count_ff  <= voas_pkg::COUNT_W'(cnt_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_note_handle  = rsp_handle_ff;
   assign rsp_stolen       = rsp_stolen_ff;
   assign rsp_active_count = rsp_count_ff;

   a_token_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[NUM_SLOTS].valid |-> (state_ff == ST_SCAN))
      else $error("search token left the chain outside of a scan");

   a_slot_within_limit: assert property (@(posedge clock) disable iff (reset)
      load |-> (CNT_W'(best_ff) < lim_ff))
      else $error("chosen slot beyond max_voices");

   a_handle_nonzero: assert property (@(posedge clock) disable iff (reset)
      handle_ff != '0)
      else $error("handle counter reached zero");

   a_load_gives_result: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid && (rsp_note_handle == $past(handle_ff))))
      else $error("result register did not take the allocated handle");

endmodule

`default_nettype wire

### rtl/voas_cell.sv
// One voice slot of the allocator chain: holds the slot state and refines the
// search token by one slot per cycle. Depends on voas_pkg.
`default_nettype none

module voas_cell #(
   parameter int NUM_SLOTS = voas_pkg::NUM_SLOTS_DEFAULT,
   parameter int IDX       = 0,
   localparam int IDX_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
   localparam int CNT_W    = $clog2(NUM_SLOTS + 1)
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire [CNT_W-1:0]           lim,
   input  voas_pkg::token_type       tok_in,
   input  wire [IDX_W-1:0]           idx_in,
   input  wire [CNT_W-1:0]           cnt_in,
   output voas_pkg::token_type       tok_out,
   output logic [IDX_W-1:0]          idx_out,
   output logic [CNT_W-1:0]          cnt_out,
   input  voas_pkg::write_type       wr,
   input  wire [IDX_W-1:0]           wr_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

   logic                          active_ff;
   logic [voas_pkg::TIME_W-1:0]   start_ff;
   logic [voas_pkg::HANDLE_W-1:0] handle_ff;

   logic                          tok_valid_ff;
   voas_pkg::token_type           tok_in_c;
   logic [IDX_W-1:0]              idx_in_c;
   voas_pkg::token_type           tok_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          in_range;
   logic                          older;
   logic                          wr_hit;

   assign in_range = (MY_POS < lim);
   assign wr_hit   = wr.en && (wr_idx == MY_IDX);
   assign older    = (IDX == 0) ||
                     (start_ff < tok_in.best_start) ||
                     ((start_ff == tok_in.best_start) && (handle_ff < tok_in.best_handle));

   always_comb begin
      tok_in_c = tok_in;
      idx_in_c = idx_in;
      if (in_range && !tok_in.found) begin
         if (!active_ff) begin
            tok_in_c.found = 1'b1;
            idx_in_c       = MY_IDX;
         end else if (older) begin
            tok_in_c.best_start  = start_ff;
            tok_in_c.best_handle = handle_ff;
            idx_in_c             = MY_IDX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_in.valid;
         if (wr_hit) begin
            active_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         start_ff  <= wr.start;
         handle_ff <= wr.handle;
      end
      tok_ff <= tok_in_c;
      idx_ff <= idx_in_c;
      cnt_ff <= CNT_W'(cnt_in + CNT_W'(active_ff));
   end

   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tok_valid_ff;
   end

   assign idx_out = idx_ff;
   assign cnt_out = cnt_ff;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench for voice_allocator_oldest_steal_unit: sends note triggers, predicts each
// allocation (lowest free slot or oldest-note steal) and checks every result field.
// Depends on voas_pkg and the unit under test; needs no files or arguments.

module tb;
   import voas_pkg::*;

   localparam int NUM_SLOTS     = NUM_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 66;
   localparam int FIXED_PHASES  = 10;
   localparam logic [CFG_W-1:0] PHASE_LIMITS [FIXED_PHASES] =
      '{5'd2, 5'd5, 5'd9, 5'd0, 5'd12, 5'd31, 5'd1, 5'd16, 5'd17, 5'd7};

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] handle;
      logic                stolen;
      logic [COUNT_W-1:0]  count;
   } alloc_result;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic [TIME_W-1:0]   req_start_time   = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [HANDLE_W-1:0] rsp_note_handle;
   logic                rsp_stolen;
   logic [COUNT_W-1:0]  rsp_active_count;
   logic                csr_wr_en        = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data      = '0;

   // predictor state
   logic                slot_busy  [NUM_SLOTS];
   logic [TIME_W-1:0]   slot_begin [NUM_SLOTS];
   logic [HANDLE_W-1:0] slot_owner [NUM_SLOTS];
   logic [HANDLE_W-1:0] handle_next;
   int                  voice_limit;

   alloc_result pending_allocs[$];
   alloc_result rsp_seen;
   logic        req_take    = 1'b0;
   logic        rsp_take    = 1'b0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          idle_pct    = 0;
   int          stall_pct   = 0;
   int          stall_hold  = 0;

   voice_allocator_oldest_steal_unit #(
      .NUM_SLOTS(NUM_SLOTS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_time  (req_start_time),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot        (rsp_slot),
      .rsp_note_handle (rsp_note_handle),
      .rsp_stolen      (rsp_stolen),
      .rsp_active_count(rsp_active_count),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   function automatic logic [TIME_W-1:0] pick_start();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(7);
         4:          return 32'hFFFF_FFFF - $urandom_range(3);
         5:          return $urandom_range(3);
         default:    return $urandom;
      endcase
   endfunction

   function automatic void set_voice_limit(input logic [CFG_W-1:0] v);
      if (v == 0) voice_limit = 1;
      else if (v > NUM_SLOTS) voice_limit = NUM_SLOTS;
      else voice_limit = v;
   endfunction

   function automatic alloc_result predict_allocation(input logic [TIME_W-1:0] t);
      alloc_result r;
      int          pick;
      int          busy_total;
      logic        found;
      found = 1'b0;
      pick = 0;
      for (int i = 0; i < voice_limit; i++) begin
         if (!found && !slot_busy[i]) begin
            pick = i;
            found = 1'b1;
         end
      end
      if (!found) begin
         for (int i = 1; i < voice_limit; i++) begin
            if (slot_begin[i] < slot_begin[pick] ||
                (slot_begin[i] == slot_begin[pick] && slot_owner[i] < slot_owner[pick])) begin
               pick = i;
            end
         end
      end
      slot_busy[pick]  = 1'b1;
      slot_begin[pick] = t;
      slot_owner[pick] = handle_next;
      r.handle = handle_next;
      handle_next = handle_next + 1;
      if (handle_next == 0) handle_next = 1;
      busy_total = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (slot_busy[i]) busy_total++;
      end
      r.slot   = pick[SLOT_W-1:0];
      r.stolen = !found;
      r.count  = busy_total[COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_error(input string msg);
      $display("[cycle %0d] mismatch: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_result();
      alloc_result want;
      if (pending_allocs.size() == 0) begin
         report_error($sformatf("unexpected result slot=%0d handle=%0h",
                                rsp_seen.slot, rsp_seen.handle));
         return;
      end
      want = pending_allocs.pop_front();
      if (rsp_seen.slot !== want.slot)
         report_error($sformatf("slot got %0d want %0d", rsp_seen.slot, want.slot));
      if (rsp_seen.handle !== want.handle)
         report_error($sformatf("note_handle got %0h want %0h", rsp_seen.handle, want.handle));
      if (rsp_seen.stolen !== want.stolen)
         report_error($sformatf("stolen got %0b want %0b", rsp_seen.stolen, want.stolen));
      if (rsp_seen.count !== want.count)
         report_error($sformatf("active_count got %0d want %0d", rsp_seen.count, want.count));
   endtask

   // sample handshakes mid-cycle; the transfer happens at the next rising edge
   always @(negedge clock) begin
      req_take = !reset && req_valid && !req_stall;
      rsp_take = !reset && rsp_valid && !rsp_stall;
      rsp_seen = {rsp_slot, rsp_note_handle, rsp_stolen, rsp_active_count};
   end

   always @(posedge clock) begin
      if (rsp_take) check_result();
   end

   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= ($urandom_range(99) < stall_pct);
         stall_hold <= pick_gap(50);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_allocs.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_trigger(input logic [TIME_W-1:0] t);
      int gap;
      gap = pick_gap(idle_pct);
      if (gap > 0) begin
         req_valid      <= 1'b0;
         req_start_time <= $urandom;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_time <= t;
      do @(posedge clock); while (!req_take);
      pending_allocs.push_back(predict_allocation(t));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_allocs.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_voices(input logic [CFG_W-1:0] v);
      wait_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CFG_W'($urandom);
      set_voice_limit(v);
   endtask

   task automatic test_default_limit();
      idle_pct  = 0;
      stall_pct = 0;
      send_trigger(32'hFFFF_FFFF);
      send_trigger(32'h0000_0000);
      send_trigger(32'd5);
      send_trigger(32'd5);
      // all four busy: steal oldest, then break an equal start time by handle
      send_trigger(32'd7);
      send_trigger(32'd3);
   endtask

   task automatic test_limit_clamp();
      idle_pct  = 30;
      stall_pct = 30;
      write_max_voices(5'd0);
      send_trigger(32'h0000_0001);
      send_trigger(32'h8000_0000);
      write_max_voices(5'd31);
      send_trigger(32'h7FFF_FFFF);
      send_trigger(32'h5555_5555);
      write_max_voices(5'd17);
      send_trigger(32'hAAAA_AAAA);
      write_max_voices(5'd2);
      send_trigger(32'h0000_0000);
      send_trigger(32'hFFFF_FFFE);
   endtask

   task automatic test_equal_start_times();
      idle_pct  = 10;
      stall_pct = 40;
      write_max_voices(5'd3);
      repeat (4) send_trigger(32'h0000_0000);
   endtask

   task automatic test_random_phases();
      logic [CFG_W-1:0] lim;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         lim = (p < FIXED_PHASES) ? PHASE_LIMITS[p] : CFG_W'($urandom);
         write_max_voices(lim);
         idle_pct  = (p % 3 == 0) ? 0 : $urandom_range(70, 10);
         stall_pct = (p % 4 == 1) ? 0 : $urandom_range(70, 10);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until every pending result is back
            if (p == 4 && n == PHASE_ITEMS / 2) wait_drain();
            send_trigger(pick_start());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_busy[i]  = 1'b0;
         slot_begin[i] = '0;
         slot_owner[i] = '0;
      end
      handle_next = 1;
      set_voice_limit(CFG_W'(MAX_VOICES_RESET));
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_default_limit();
      test_limit_clamp();
      test_equal_start_times();
      test_random_phases();
      wait_drain();
      repeat (NUM_SLOTS + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
